### src/slot_table_first_free_top_assert.svh
// Assertion macros for the slot table block.
`ifndef SLOT_TABLE_FIRST_FREE_TOP_ASSERT_SVH
`define SLOT_TABLE_FIRST_FREE_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SFT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/sft_pkg.sv
package sft_pkg;

  // Operation codes carried in the func field.
  localparam logic [2:0] FUNC_READ    = 3'd0;
  localparam logic [2:0] FUNC_ADD     = 3'd1;
  localparam logic [2:0] FUNC_DROP    = 3'd2;
  localparam logic [2:0] FUNC_MOVE    = 3'd3;
  localparam logic [2:0] FUNC_REPLACE = 3'd4;

  // One request beat.
  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  slot_index;
    logic [7:0]  dest_index;
    logic [15:0] item_handle;
  } req_t;

  // One result beat.
  typedef struct packed {
    logic        ok;
    logic [15:0] read_handle;
    logic [5:0]  occupied_count;
  } rsp_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MV_RD_DST,
    ST_MV_WR_DST,
    ST_MV_WR_SRC
  } state_e;

  // Step commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic mv_rd_dst;
    logic mv_wr_dst;
    logic mv_wr_src;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic move_go;
    logic is_move;
  } sts_t;

endpackage

### src/slot_table_first_free_top.sv
// Channel   Handshake                   Payload
// request   start / busy                req_i  (sft_pkg::req_t)
// result    result_strobe_o, one cycle  rsp_o  (sft_pkg::rsp_t)
//
// An item passes from accept through an execute step on the single-port handle
// store to a result cycle in which busy is low again and the next item can be
// accepted. A successful move takes a longer path, set by its four store accesses.
// Reset clears the occupancy bits and count, so every slot reads empty.
// The result strobe lasts one cycle and cannot be held off.
`include "slot_table_first_free_top_assert.svh"

module slot_table_first_free_top #(
  parameter int SLOT_COUNT  = 32,
  parameter int HANDLE_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  sft_pkg::req_t req_i,
  output logic          result_strobe_o,
  output sft_pkg::rsp_t rsp_o
);

  sft_pkg::cmd_t cmd;
  sft_pkg::sts_t sts;

  // Sequencer.
  sft_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  // Store, occupancy and result registers.
  sft_dpath #(
    .SLOT_COUNT  (SLOT_COUNT),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .strobe_o (result_strobe_o),
    .rsp_o    (rsp_o)
  );

  // The result beat falls in a cycle where the block is ready again.
  `SFT_ASSERT_NOW(a_strobe_not_busy, result_strobe_o, !busy, "result strobe while busy")
  // An accepted beat always passes through the execute state before its result.
  `SFT_ASSERT_NEXT(a_accept_exec, start && !busy, busy && cmd.exec && !result_strobe_o,
                   "accept not followed by execute")
  // A rejected operation never returns a handle.
  `SFT_ASSERT_NOW(a_reject_no_handle, result_strobe_o && !rsp_o.ok,
                  rsp_o.read_handle == 16'b0, "rejected result carries a handle")
  // The long move path starts only for a move that succeeds.
  `SFT_ASSERT_NEXT(a_move_path, cmd.exec && !sts.move_go, !cmd.mv_rd_dst,
                   "move sequence entered without a valid move")

endmodule

### src/sft_ctrl.sv
module sft_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  sft_pkg::sts_t sts_i,
  output sft_pkg::cmd_t cmd_o
);

  sft_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sft_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state. A move that will succeed takes the long path of four accesses.
  always_comb begin
    state_d = state_q;
    case (state_q)
      sft_pkg::ST_IDLE: begin
        if (start_i) state_d = sft_pkg::ST_EXEC;
      end
      sft_pkg::ST_EXEC: begin
        state_d = sts_i.move_go ? sft_pkg::ST_MV_RD_DST : sft_pkg::ST_IDLE;
      end
      sft_pkg::ST_MV_RD_DST: state_d = sft_pkg::ST_MV_WR_DST;
      sft_pkg::ST_MV_WR_DST: state_d = sft_pkg::ST_MV_WR_SRC;
      sft_pkg::ST_MV_WR_SRC: state_d = sft_pkg::ST_IDLE;
      default:               state_d = sft_pkg::ST_IDLE;
    endcase
  end

  // Outputs decoded from the current state.
  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      sft_pkg::ST_IDLE: begin
        busy_o        = 1'b0;
        cmd_o.capture = start_i;
      end
      sft_pkg::ST_EXEC: begin
        cmd_o.exec   = 1'b1;
        cmd_o.finish = !sts_i.move_go;
      end
      sft_pkg::ST_MV_RD_DST: cmd_o.mv_rd_dst = 1'b1;
      sft_pkg::ST_MV_WR_DST: cmd_o.mv_wr_dst = 1'b1;
      sft_pkg::ST_MV_WR_SRC: begin
        cmd_o.mv_wr_src = 1'b1;
        cmd_o.finish    = 1'b1;
      end
      default: busy_o = 1'b1;
    endcase
  end

endmodule

### src/sft_dpath.sv
module sft_dpath #(
  parameter int SLOT_COUNT  = 32,
  parameter int HANDLE_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sft_pkg::req_t req_i,
  input  sft_pkg::cmd_t cmd_i,
  output sft_pkg::sts_t sts_o,
  output logic          strobe_o,
  output sft_pkg::rsp_t rsp_o
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  sft_pkg::req_t          req_q;
  logic [HANDLE_BITS-1:0] mem_q [SLOT_COUNT];
  logic [HANDLE_BITS-1:0] rdata_q;
  logic [HANDLE_BITS-1:0] a_q;
  logic [SLOT_COUNT-1:0]  occ_q, occ_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   ok_q;
  logic                   strobe_q;

  logic [HANDLE_BITS+15:0] h_ext;
  logic [HANDLE_BITS-1:0]  h;
  logic [HANDLE_BITS+15:0] rd_ext;
  logic [CNT_W+5:0]        cnt_ext;
  logic [IDX_W-1:0]        src_a, dst_a, free_a;
  logic                    src_in, dst_in, occ_src, occ_dst, free_found, h_nz;
  logic                    ok_c;
  logic                    mem_we, mem_re;
  logic [IDX_W-1:0]        mem_addr;
  logic [HANDLE_BITS-1:0]  mem_wdata;

  // Request register, loaded when a beat is accepted.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) req_q <= req_i;
  end

  // Operand decode: masked handle, slot addresses and range checks.
  assign h_ext   = {{HANDLE_BITS{1'b0}}, req_q.item_handle};
  assign h       = h_ext[HANDLE_BITS-1:0];
  assign h_nz    = |h;
  assign src_a   = req_q.slot_index[IDX_W-1:0];
  assign dst_a   = req_q.dest_index[IDX_W-1:0];
  assign src_in  = {1'b0, req_q.slot_index} < 9'(SLOT_COUNT);
  assign dst_in  = {1'b0, req_q.dest_index} < 9'(SLOT_COUNT);
  assign occ_src = src_in && occ_q[src_a];
  assign occ_dst = dst_in && occ_q[dst_a];

  // Lowest empty slot, by priority over the occupancy bits.
  always_comb begin
    free_a = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!occ_q[i]) free_a = IDX_W'(i);
    end
  end
  assign free_found = ~&occ_q;

  // Success of the operation, judged in the execute step.
  always_comb begin
    case (req_q.func)
      sft_pkg::FUNC_READ:    ok_c = occ_src;
      sft_pkg::FUNC_ADD:     ok_c = h_nz && free_found;
      sft_pkg::FUNC_DROP:    ok_c = occ_src;
      sft_pkg::FUNC_MOVE:    ok_c = occ_src && dst_in;
      sft_pkg::FUNC_REPLACE: ok_c = occ_dst && h_nz;
      default:               ok_c = 1'b0;
    endcase
  end

  assign sts_o.is_move = (req_q.func == sft_pkg::FUNC_MOVE);
  assign sts_o.move_go = sts_o.is_move && ok_c;

  // Store port control: one read or one write per cycle.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = src_a;
    mem_wdata = h;
    if (cmd_i.exec) begin
      case (req_q.func)
        sft_pkg::FUNC_READ: mem_re = ok_c;
        sft_pkg::FUNC_ADD: begin
          mem_we   = ok_c;
          mem_addr = free_a;
        end
        sft_pkg::FUNC_REPLACE: begin
          mem_we   = ok_c;
          mem_addr = dst_a;
        end
        sft_pkg::FUNC_MOVE: mem_re = ok_c;
        default: mem_re = 1'b0;
      endcase
    end
    if (cmd_i.mv_rd_dst) begin
      mem_re   = 1'b1;
      mem_addr = dst_a;
    end
    if (cmd_i.mv_wr_dst) begin
      mem_we    = 1'b1;
      mem_addr  = dst_a;
      mem_wdata = a_q;
    end
    if (cmd_i.mv_wr_src) begin
      mem_we    = 1'b1;
      mem_addr  = src_a;
      mem_wdata = rdata_q;
    end
  end

  // Single-port handle store with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end else if (mem_re) begin
      rdata_q <= mem_q[mem_addr];
    end
  end

  // Source handle of a move is parked while the destination is read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mv_rd_dst) a_q <= rdata_q;
  end

  // Occupancy and count updates.
  always_comb begin
    occ_d = occ_q;
    cnt_d = cnt_q;
    if (cmd_i.exec && ok_c) begin
      if (req_q.func == sft_pkg::FUNC_ADD) begin
        occ_d[free_a] = 1'b1;
        cnt_d         = cnt_q + CNT_W'(1);
      end else if (req_q.func == sft_pkg::FUNC_DROP) begin
        occ_d[src_a] = 1'b0;
        cnt_d        = cnt_q - CNT_W'(1);
      end
    end
    // A swap leaves the count alone; the source takes the old destination state.
    if (cmd_i.mv_wr_src) begin
      occ_d[dst_a] = 1'b1;
      occ_d[src_a] = occ_q[dst_a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q    <= '0;
      cnt_q    <= '0;
      ok_q     <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      occ_q    <= occ_d;
      cnt_q    <= cnt_d;
      strobe_q <= cmd_i.finish;
      if (cmd_i.exec) ok_q <= ok_c;
    end
  end

  // Result beat, built from registers that hold still through the strobe cycle.
  assign rd_ext  = {16'b0, rdata_q};
  assign cnt_ext = {6'b0, cnt_q};

  assign strobe_o             = strobe_q;
  assign rsp_o.ok             = ok_q;
  assign rsp_o.read_handle    = (ok_q && req_q.func == sft_pkg::FUNC_READ) ? rd_ext[15:0]
                                                                           : 16'b0;
  assign rsp_o.occupied_count = cnt_ext[5:0];

endmodule
